@@ rtl/core/ddmw_pkg.sv @@
// Shared types, register indexes and command codes of the drive mixer with watchdog.
package ddmw_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_W      = 16;
    localparam int MAG_W      = 17;
    localparam int SUM_W      = 18;

    localparam logic [1:0] CMD_DRIVE  = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [1:0] DIR_COAST = 2'd0;
    localparam logic [1:0] DIR_FWD   = 2'd1;
    localparam logic [1:0] DIR_REV   = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_IN_DZ   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_OUT_DZ  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PWM_TOP = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 3'd4;

    localparam logic [11:0] RST_IN_DZ   = 12'd205;
    localparam logic [11:0] RST_OUT_DZ  = 12'd41;
    localparam logic [15:0] RST_PWM_TOP = 16'd999;
    localparam logic [1:0]  RST_INVERT  = 2'd2;
    localparam logic [15:0] RST_TIMEOUT = 16'd500;

    typedef struct packed {
        logic [1:0]          cmd;
        logic signed [15:0]  linear;
        logic signed [15:0]  angular;
    } t_in_item;

    typedef struct packed {
        logic [15:0] left_level;
        logic [1:0]  left_dir;
        logic [15:0] right_level;
        logic [1:0]  right_dir;
        logic        drive_active;
        logic        timed_out;
    } t_out_item;

    typedef struct packed {
        logic [11:0] cmd_dz;
        logic [11:0] wheel_dz;
        logic [15:0] pwm_top;
        logic [1:0]  invert_mask;
        logic [15:0] timeout_ticks;
    } t_cfg;

endpackage

@@ rtl/core/ddmw_cfg.sv @@
// Configuration register file of the drive mixer.
module ddmw_cfg (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ddmw_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ddmw_pkg::CFG_W-1:0]      i_cfg_data,
    output ddmw_pkg::t_cfg                  o_cfg
);
    import ddmw_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_IN_DZ:   n_cfg.cmd_dz        = i_cfg_data[11:0];
                REG_OUT_DZ:  n_cfg.wheel_dz      = i_cfg_data[11:0];
                REG_PWM_TOP: n_cfg.pwm_top       = i_cfg_data[15:0];
                REG_INVERT:  n_cfg.invert_mask   = i_cfg_data[1:0];
                REG_TIMEOUT: n_cfg.timeout_ticks = i_cfg_data[15:0];
                default:     n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cmd_dz        <= RST_IN_DZ;
            r_cfg.wheel_dz      <= RST_OUT_DZ;
            r_cfg.pwm_top       <= RST_PWM_TOP;
            r_cfg.invert_mask   <= RST_INVERT;
            r_cfg.timeout_ticks <= RST_TIMEOUT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/core/ddmw_div.sv @@
// Bit-serial restoring divider for wheel normalization, one quotient bit per cycle.
module ddmw_div #(
    parameter int FRAC_BITS = 12
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [ddmw_pkg::MAG_W-1:0]   i_num,
    input  logic [ddmw_pkg::MAG_W-1:0]   i_den,
    output logic                         o_done,
    output logic [FRAC_BITS:0]           o_quo
);
    import ddmw_pkg::*;

    localparam int               CNT_W = $clog2(FRAC_BITS + 1);
    localparam logic [CNT_W-1:0] LAST  = CNT_W'(FRAC_BITS);

    logic [MAG_W:0]     r_rem, n_rem;
    logic [MAG_W-1:0]   r_den, n_den;
    logic [FRAC_BITS:0] r_quo, n_quo;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic               ge;
    logic [MAG_W:0]     diff;

    always_comb begin
        ge     = r_rem >= {1'b0, r_den};
        diff   = ge ? (r_rem - {1'b0, r_den}) : r_rem;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = {1'b0, i_num};
            n_den  = i_den;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_rem = {diff[MAG_W-1:0], 1'b0};
            n_quo = {r_quo[FRAC_BITS-1:0], ge};
            n_cnt = r_cnt + CNT_W'(1);
            if (r_cnt == LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("divider started while busy");

    a_num_le_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (i_num <= i_den))
        else $error("dividend exceeds divisor");

    a_done_ends_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_busy && $past(r_busy)))
        else $error("done without a finished division");
`endif

endmodule

@@ rtl/core/differential_drive_mixer_watchdog.sv @@
// Top level: differential drive mixer with PWM mapping and command watchdog.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one item per
// transfer: a drive command, a tick or a stop request. Each item yields
// exactly one result on the output channel (o_out_valid / i_out_ready /
// o_out_data): the held wheel levels, directions, active flag and whether
// this tick fired the watchdog.
// One item is processed at a time; o_in_ready is low while it is in work.
// Tick, stop and unused codes pass from the taken item through EXEC to DONE.
// A drive command that needs no normalization passes through EXEC, PREP,
// MUL_L, MUL_R and APPLY_R to DONE; one whose larger wheel magnitude exceeds
// 1.0 adds DIV_L and DIV_R after PREP, where one serial divider normalizes
// the left and then the right wheel, one quotient bit per cycle.
// The result sits in an output register; the next item is taken while it
// waits, and a finished item holds in its last step while the receiver
// stalls. Configuration writes via i_cfg_we / i_cfg_addr / i_cfg_data take
// effect in the next cycle; the user must make them only while the block is
// idle; the block does not enforce it. Synchronous reset stops both wheels,
// clears the active flag and elapsed count and loads the register defaults.
module differential_drive_mixer_watchdog #(
    parameter int FRAC_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ddmw_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ddmw_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ddmw_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ddmw_pkg::CFG_W-1:0]      i_cfg_data
);
    import ddmw_pkg::*;

    localparam int               PROD_W  = FRAC_BITS + 17;
    localparam logic [MAG_W-1:0] ONE_MAG = MAG_W'(1) << FRAC_BITS;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_EXEC    = 4'd1;
    localparam logic [3:0] S_PREP    = 4'd2;
    localparam logic [3:0] S_DIV_L   = 4'd3;
    localparam logic [3:0] S_DIV_R   = 4'd4;
    localparam logic [3:0] S_MUL_L   = 4'd5;
    localparam logic [3:0] S_MUL_R   = 4'd6;
    localparam logic [3:0] S_APPLY_R = 4'd7;
    localparam logic [3:0] S_DONE    = 4'd8;

    function automatic logic [MAG_W-1:0] f_mag(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] a;
        a = v[SUM_W-1] ? (~v + SUM_W'(1)) : v;
        return a[MAG_W-1:0];
    endfunction

    t_cfg cfg;

    logic [3:0]          r_state, n_state;
    logic [1:0]          r_cmd, n_cmd;
    logic [15:0]         r_lin, n_lin;
    logic [15:0]         r_ang, n_ang;
    logic [MAG_W-1:0]    r_lmag, n_lmag;
    logic [MAG_W-1:0]    r_rmag, n_rmag;
    logic                r_lneg, n_lneg;
    logic                r_rneg, n_rneg;
    logic [MAG_W-1:0]    r_max, n_max;
    logic [PROD_W-1:0]   r_prod, n_prod;
    logic [15:0]         r_left_level, n_left_level;
    logic [1:0]          r_left_dir, n_left_dir;
    logic [15:0]         r_right_level, n_right_level;
    logic [1:0]          r_right_dir, n_right_dir;
    logic                r_active, n_active;
    logic [15:0]         r_elapsed, n_elapsed;
    logic                r_fired, n_fired;
    logic                r_out_valid, n_out_valid;
    t_out_item           r_out, n_out;

    logic                div_start;
    logic [MAG_W-1:0]    div_num;
    logic                div_done;
    logic [FRAC_BITS:0]  div_quo;

    logic [SUM_W-1:0]    lin_ext, ang_ext, lin_z, ang_z, l_sum, r_sum;
    logic [MAG_W-1:0]    lin_mag, ang_mag, l_mag, r_mag;
    logic [15:0]         tick_elapsed;
    logic                tick_fire;
    logic [MAG_W-1:0]    w_mag;
    logic                w_neg;
    logic                w_on;
    logic [1:0]          w_dir;
    logic [15:0]         w_level;
    logic [FRAC_BITS:0]  mul_a;
    logic                out_free;

    ddmw_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    ddmw_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_max),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;

    assign div_start = ((r_state == S_PREP) && (r_max > ONE_MAG)) ||
                       ((r_state == S_DIV_L) && div_done);
    assign div_num   = (r_state == S_PREP) ? r_lmag : r_rmag;

    always_comb begin
        lin_ext = {{(SUM_W-16){r_lin[15]}}, r_lin};
        ang_ext = {{(SUM_W-16){r_ang[15]}}, r_ang};
        lin_mag = f_mag(lin_ext);
        ang_mag = f_mag(ang_ext);
        lin_z   = (lin_mag < {5'b0, cfg.cmd_dz}) ? '0 : lin_ext;
        ang_z   = (ang_mag < {5'b0, cfg.cmd_dz}) ? '0 : ang_ext;
        l_sum   = lin_z - ang_z;
        r_sum   = lin_z + ang_z;
        l_mag   = f_mag(l_sum);
        r_mag   = f_mag(r_sum);

        tick_elapsed = (r_elapsed == 16'hFFFF) ? r_elapsed : (r_elapsed + 16'd1);
        tick_fire    = r_active && (tick_elapsed >= cfg.timeout_ticks);

        mul_a   = (r_state == S_MUL_L) ? r_lmag[FRAC_BITS:0] : r_rmag[FRAC_BITS:0];
        w_mag   = (r_state == S_MUL_R) ? r_lmag : r_rmag;
        w_neg   = (r_state == S_MUL_R) ? (r_lneg ^ cfg.invert_mask[0])
                                       : (r_rneg ^ cfg.invert_mask[1]);
        w_on    = w_mag > {5'b0, cfg.wheel_dz};
        w_dir   = w_on ? (w_neg ? DIR_REV : DIR_FWD) : DIR_COAST;
        w_level = w_on ? r_prod[FRAC_BITS+15:FRAC_BITS] : 16'd0;
    end

    always_comb begin
        n_state       = r_state;
        n_cmd         = r_cmd;
        n_lin         = r_lin;
        n_ang         = r_ang;
        n_lmag        = r_lmag;
        n_rmag        = r_rmag;
        n_lneg        = r_lneg;
        n_rneg        = r_rneg;
        n_max         = r_max;
        n_prod        = r_prod;
        n_left_level  = r_left_level;
        n_left_dir    = r_left_dir;
        n_right_level = r_right_level;
        n_right_dir   = r_right_dir;
        n_active      = r_active;
        n_elapsed     = r_elapsed;
        n_fired       = r_fired;
        n_out_valid   = r_out_valid;
        n_out         = r_out;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.cmd;
                    n_lin   = i_in_data.linear;
                    n_ang   = i_in_data.angular;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_fired = 1'b0;
                n_state = S_DONE;
                unique case (r_cmd)
                    CMD_DRIVE: begin
                        n_lmag    = l_mag;
                        n_rmag    = r_mag;
                        n_lneg    = l_sum[SUM_W-1];
                        n_rneg    = r_sum[SUM_W-1];
                        n_max     = (l_mag > r_mag) ? l_mag : r_mag;
                        n_active  = (l_mag > {5'b0, cfg.wheel_dz}) ||
                                    (r_mag > {5'b0, cfg.wheel_dz});
                        n_elapsed = '0;
                        n_state   = S_PREP;
                    end
                    CMD_TICK: begin
                        n_elapsed = tick_elapsed;
                        if (tick_fire) begin
                            n_left_level  = '0;
                            n_left_dir    = DIR_COAST;
                            n_right_level = '0;
                            n_right_dir   = DIR_COAST;
                            n_active      = 1'b0;
                            n_fired       = 1'b1;
                        end
                    end
                    CMD_STOP: begin
                        n_left_level  = '0;
                        n_left_dir    = DIR_COAST;
                        n_right_level = '0;
                        n_right_dir   = DIR_COAST;
                        n_active      = 1'b0;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_PREP: begin
                n_state = (r_max > ONE_MAG) ? S_DIV_L : S_MUL_L;
            end
            S_DIV_L: begin
                if (div_done) begin
                    n_lmag  = {{(MAG_W-FRAC_BITS-1){1'b0}}, div_quo};
                    n_state = S_DIV_R;
                end
            end
            S_DIV_R: begin
                if (div_done) begin
                    n_rmag  = {{(MAG_W-FRAC_BITS-1){1'b0}}, div_quo};
                    n_state = S_MUL_L;
                end
            end
            S_MUL_L: begin
                n_prod  = PROD_W'(mul_a) * PROD_W'(cfg.pwm_top);
                n_state = S_MUL_R;
            end
            S_MUL_R: begin
                n_left_level = w_level;
                n_left_dir   = w_dir;
                n_prod       = PROD_W'(mul_a) * PROD_W'(cfg.pwm_top);
                n_state      = S_APPLY_R;
            end
            S_APPLY_R: begin
                n_right_level = w_level;
                n_right_dir   = w_dir;
                n_state       = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.left_level   = r_left_level;
                    n_out.left_dir     = r_left_dir;
                    n_out.right_level  = r_right_level;
                    n_out.right_dir    = r_right_dir;
                    n_out.drive_active = r_active;
                    n_out.timed_out    = r_fired;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_left_level  <= '0;
            r_left_dir    <= DIR_COAST;
            r_right_level <= '0;
            r_right_dir   <= DIR_COAST;
            r_active      <= 1'b0;
            r_elapsed     <= '0;
            r_fired       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_left_level  <= n_left_level;
            r_left_dir    <= n_left_dir;
            r_right_level <= n_right_level;
            r_right_dir   <= n_right_dir;
            r_active      <= n_active;
            r_elapsed     <= n_elapsed;
            r_fired       <= n_fired;
            r_out_valid   <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_lin  <= n_lin;
        r_ang  <= n_ang;
        r_lmag <= n_lmag;
        r_rmag <= n_rmag;
        r_lneg <= n_lneg;
        r_rneg <= n_rneg;
        r_max  <= n_max;
        r_prod <= n_prod;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken again before item finished");

    a_timeout_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.timed_out) |->
        (o_out_data.left_dir == DIR_COAST && o_out_data.right_dir == DIR_COAST &&
         !o_out_data.drive_active))
        else $error("watchdog fired without stopping wheels");

    a_coast_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.left_dir == DIR_COAST) |->
        (o_out_data.left_level == 16'd0))
        else $error("coasting left wheel with nonzero level");

    a_dir_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.right_dir == DIR_COAST ||
                         o_out_data.right_dir == DIR_FWD ||
                         o_out_data.right_dir == DIR_REV))
        else $error("right bridge drives both sides");
`endif

endmodule

@@ tb/ddmw_mix_checker.sv @@
`timescale 1ns / 100ps
// Checker for the drive mixer: predicts each result from the observed transfers and compares.
module ddmw_mix_checker #(
    parameter int FRAC_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  ddmw_pkg::t_in_item              i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  ddmw_pkg::t_out_item             i_out_data,
    input  logic                            i_cfg_we,
    input  logic [ddmw_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ddmw_pkg::CFG_W-1:0]      i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_results,
    output int                              o_fires
);
    import ddmw_pkg::*;

    localparam longint UNIT = longint'(1) << FRAC_BITS;

    logic [11:0] in_dz;
    logic [11:0] out_dz;
    logic [15:0] pwm_top;
    logic [1:0]  inv_mask;
    logic [15:0] timeout;

    logic [15:0] left_level;
    logic [1:0]  left_dir;
    logic [15:0] right_level;
    logic [1:0]  right_dir;
    logic        active;
    logic [15:0] elapsed;

    t_out_item wheel_q[$];
    t_out_item want;

    initial begin
        o_errors  = 0;
        o_pending = 0;
        o_results = 0;
        o_fires   = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, exp_val);
        o_errors++;
    endtask

    function automatic void stop_wheels();
        left_level  = '0;
        left_dir    = DIR_COAST;
        right_level = '0;
        right_dir   = DIR_COAST;
        active      = 1'b0;
    endfunction

    function automatic void reset_model();
        in_dz    = RST_IN_DZ;
        out_dz   = RST_OUT_DZ;
        pwm_top  = RST_PWM_TOP;
        inv_mask = RST_INVERT;
        timeout  = RST_TIMEOUT;
        stop_wheels();
        elapsed  = '0;
    endfunction

    function automatic void apply_reg_write(input logic [CFG_ADDR_W-1:0] idx,
                                            input logic [CFG_W-1:0] val);
        case (idx)
            REG_IN_DZ:   in_dz    = val[11:0];
            REG_OUT_DZ:  out_dz   = val[11:0];
            REG_PWM_TOP: pwm_top  = val;
            REG_INVERT:  inv_mask = val[1:0];
            REG_TIMEOUT: timeout  = val;
            default: ;
        endcase
    endfunction

    function automatic void map_wheel(input longint s, output logic [15:0] lvl,
                                      output logic [1:0] dir);
        longint dz;
        longint a;
        dz = longint'(out_dz);
        a  = (s < 0) ? -s : s;
        if (s > dz) begin
            dir = DIR_FWD;
            lvl = 16'((a * longint'(pwm_top)) / UNIT);
        end else if (s < -dz) begin
            dir = DIR_REV;
            lvl = 16'((a * longint'(pwm_top)) / UNIT);
        end else begin
            dir = DIR_COAST;
            lvl = '0;
        end
    endfunction

    function automatic t_out_item mix_step(input t_in_item it);
        longint lin;
        longint ang;
        longint l;
        longint r;
        longint al;
        longint ar;
        longint m;
        logic fired;
        t_out_item res;
        fired = 1'b0;
        case (it.cmd)
            CMD_DRIVE: begin
                lin = longint'($signed(it.linear));
                ang = longint'($signed(it.angular));
                if (((lin < 0) ? -lin : lin) < longint'(in_dz))
                    lin = 0;
                if (((ang < 0) ? -ang : ang) < longint'(in_dz))
                    ang = 0;
                l  = lin - ang;
                r  = lin + ang;
                al = (l < 0) ? -l : l;
                ar = (r < 0) ? -r : r;
                active = (al > longint'(out_dz)) || (ar > longint'(out_dz));
                m = (al > ar) ? al : ar;
                if (m > UNIT) begin
                    l = (l * UNIT) / m;
                    r = (r * UNIT) / m;
                end
                if (inv_mask[0])
                    l = -l;
                if (inv_mask[1])
                    r = -r;
                map_wheel(l, left_level, left_dir);
                map_wheel(r, right_level, right_dir);
                elapsed = '0;
            end
            CMD_TICK: begin
                if (elapsed != 16'hFFFF)
                    elapsed = elapsed + 16'd1;
                if (active && elapsed >= timeout) begin
                    stop_wheels();
                    fired = 1'b1;
                end
            end
            CMD_STOP: stop_wheels();
            default: ;
        endcase
        res.left_level   = left_level;
        res.left_dir     = left_dir;
        res.right_level  = right_level;
        res.right_dir    = right_dir;
        res.drive_active = active;
        res.timed_out    = fired;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_model();
            wheel_q.delete();
        end else begin
            if (i_cfg_we)
                apply_reg_write(i_cfg_addr, i_cfg_data);
            if (i_out_valid && i_out_ready) begin
                if (wheel_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = wheel_q.pop_front();
                    o_results++;
                    if (want.timed_out)
                        o_fires++;
                    if (i_out_data.left_level !== want.left_level)
                        report_mismatch("left_level", i_out_data.left_level, want.left_level);
                    if (i_out_data.left_dir !== want.left_dir)
                        report_mismatch("left_dir", i_out_data.left_dir, want.left_dir);
                    if (i_out_data.right_level !== want.right_level)
                        report_mismatch("right_level", i_out_data.right_level,
                                        want.right_level);
                    if (i_out_data.right_dir !== want.right_dir)
                        report_mismatch("right_dir", i_out_data.right_dir, want.right_dir);
                    if (i_out_data.drive_active !== want.drive_active)
                        report_mismatch("drive_active", i_out_data.drive_active,
                                        want.drive_active);
                    if (i_out_data.timed_out !== want.timed_out)
                        report_mismatch("timed_out", i_out_data.timed_out, want.timed_out);
                end
            end
            if (i_in_valid && i_in_ready)
                wheel_q.push_back(mix_step(i_in_data));
        end
        o_pending <= wheel_q.size();
    end

endmodule

@@ tb/differential_drive_mixer_watchdog_tb.sv @@
`timescale 1ns / 100ps
// Testbench top for the drive mixer with watchdog: stimulus, idling, configuration and verdict.
module differential_drive_mixer_watchdog_tb;
    import ddmw_pkg::*;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    logic                  in_ready;
    t_in_item              in_data;
    logic                  out_valid;
    logic                  out_ready;
    t_out_item             out_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_W-1:0]      cfg_data;

    int errors;
    int pending;
    int results;
    int fires;

    logic [11:0] cur_in_dz;
    logic [11:0] cur_out_dz;
    logic [15:0] cur_timeout;
    bit          tx_calm;
    bit          rx_calm;
    int          items_sent;
    int          settings_run;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    differential_drive_mixer_watchdog #(
        .FRAC_BITS(12)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data)
    );

    ddmw_mix_checker #(
        .FRAC_BITS(12)
    ) u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .i_in_ready (in_ready),
        .i_in_data  (in_data),
        .i_out_valid(out_valid),
        .i_out_ready(out_ready),
        .i_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_addr (cfg_addr),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results),
        .o_fires    (fires)
    );

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_speed();
        int v;
        case ($urandom_range(0, 9))
            0, 1:    v = $urandom_range(0, 65535);
            2, 3, 4: v = int'($urandom_range(0, 12000)) - 6000;
            5, 6:    v = int'(cur_in_dz) + int'($urandom_range(0, 2)) - 1;
            7:       v = int'(cur_out_dz) + int'($urandom_range(0, 2)) - 1;
            8: begin
                case ($urandom_range(0, 4))
                    0:       v = -32768;
                    1:       v = 32767;
                    2:       v = 0;
                    3:       v = 4096;
                    default: v = -4096;
                endcase
            end
            default: v = int'($urandom_range(0, 8192)) - 4096;
        endcase
        if ($urandom_range(0, 1) && v > 0 && v < 32768)
            v = -v;
        return 16'(v);
    endfunction

    function automatic t_in_item make_item(input logic [1:0] cmd, input int lin, input int ang);
        t_in_item it;
        it.cmd     = cmd;
        it.linear  = 16'(lin);
        it.angular = 16'(ang);
        return it;
    endfunction

    function automatic t_in_item rand_drive();
        return make_item(CMD_DRIVE, int'(pick_speed()), int'(pick_speed()));
    endfunction

    function automatic t_in_item rand_tick();
        return make_item(CMD_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535));
    endfunction

    task automatic push_item(input t_in_item it);
        int gap;
        gap = tx_calm ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        forever begin
            @(negedge i_clk);
            if (in_ready)
                break;
        end
        @(posedge i_clk);
        items_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic [11:0] in_dz, input logic [11:0] out_dz,
                              input logic [15:0] top, input logic [1:0] inv,
                              input logic [15:0] tmo);
        wait_drained();
        repeat (8) @(posedge i_clk);
        write_reg(REG_IN_DZ, {4'b0, in_dz});
        write_reg(REG_OUT_DZ, {4'b0, out_dz});
        write_reg(REG_PWM_TOP, top);
        write_reg(REG_INVERT, {14'b0, inv});
        write_reg(REG_TIMEOUT, tmo);
        cfg_we      <= 1'b0;
        @(posedge i_clk);
        cur_in_dz   = in_dz;
        cur_out_dz  = out_dz;
        cur_timeout = tmo;
        settings_run++;
    endtask

    task automatic random_config();
        logic [11:0] in_dz;
        logic [11:0] out_dz;
        logic [15:0] top;
        logic [15:0] tmo;
        case ($urandom_range(0, 3))
            0:       in_dz = 12'd0;
            1:       in_dz = 12'd4095;
            default: in_dz = 12'($urandom_range(0, 700));
        endcase
        case ($urandom_range(0, 3))
            0:       out_dz = 12'd0;
            1:       out_dz = 12'd4095;
            default: out_dz = 12'($urandom_range(0, 300));
        endcase
        case ($urandom_range(0, 4))
            0:       top = 16'd0;
            1:       top = 16'd1;
            2:       top = 16'd65535;
            3:       top = 16'd999;
            default: top = 16'($urandom_range(0, 65535));
        endcase
        case ($urandom_range(0, 9))
            0:       tmo = 16'd0;
            1:       tmo = 16'd1;
            2:       tmo = 16'($urandom_range(41, 65535));
            default: tmo = 16'($urandom_range(2, 40));
        endcase
        set_config(in_dz, out_dz, top, 2'($urandom_range(0, 3)), tmo);
    endtask

    task automatic run_traffic(input int count);
        int done;
        int ticks;
        t_in_item it;
        done = 0;
        while (done < count) begin
            if ($urandom_range(0, 9) < 7) begin
                push_item(rand_drive());
                done++;
                if (cur_timeout <= 40)
                    ticks = $urandom_range(0, int'(cur_timeout) + 3);
                else
                    ticks = $urandom_range(0, 12);
                repeat (ticks) begin
                    push_item(rand_tick());
                    done++;
                end
                if ($urandom_range(0, 3) == 0) begin
                    push_item(make_item(CMD_STOP, $urandom_range(0, 65535),
                                        $urandom_range(0, 65535)));
                    done++;
                end
            end else begin
                it = make_item(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                               $urandom_range(0, 65535));
                push_item(it);
                if (it.cmd != CMD_UNUSED)
                    done++;
            end
            if ($urandom_range(0, 60) == 0)
                wait_drained();
        end
    endtask

    initial begin
        int stall;
        stall = 0;
        out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                stall--;
            end else begin
                out_ready <= 1'b1;
                if (!rx_calm && $urandom_range(0, 99) < 25)
                    stall = pick_gap();
            end
        end
    end

    initial begin
        #50_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        i_rst_n      <= 1'b0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        cfg_we       <= 1'b0;
        cfg_addr     <= '0;
        cfg_data     <= '0;
        cur_in_dz    = RST_IN_DZ;
        cur_out_dz   = RST_OUT_DZ;
        cur_timeout  = RST_TIMEOUT;
        tx_calm      = 1'b0;
        rx_calm      = 1'b0;
        items_sent   = 0;
        settings_run = 1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        push_item(make_item(CMD_DRIVE, 0, 0));
        push_item(make_item(CMD_DRIVE, 32767, 0));
        push_item(make_item(CMD_DRIVE, -32768, 0));
        push_item(make_item(CMD_DRIVE, 0, 32767));
        push_item(make_item(CMD_DRIVE, 0, -32768));
        push_item(make_item(CMD_DRIVE, 32767, 32767));
        push_item(make_item(CMD_DRIVE, -32768, 32767));
        push_item(make_item(CMD_DRIVE, 205, 0));
        push_item(make_item(CMD_DRIVE, 204, -204));
        push_item(make_item(CMD_DRIVE, 4096, 1000));
        push_item(make_item(CMD_UNUSED, 1234, -1234));
        push_item(make_item(CMD_STOP, 0, 0));
        push_item(make_item(CMD_TICK, 0, 0));

        set_config(12'd0, 12'd41, 16'd999, 2'd0, 16'd2);
        push_item(make_item(CMD_DRIVE, 41, 0));
        push_item(make_item(CMD_DRIVE, 42, 0));
        push_item(make_item(CMD_DRIVE, -42, 0));
        push_item(make_item(CMD_DRIVE, 4096, 0));
        push_item(make_item(CMD_DRIVE, 4097, 0));
        push_item(make_item(CMD_TICK, 0, 0));
        push_item(make_item(CMD_TICK, 0, 0));
        push_item(make_item(CMD_TICK, 0, 0));
        push_item(make_item(CMD_DRIVE, 100, 50));
        push_item(make_item(CMD_STOP, -1, -1));

        set_config(12'd0, 12'd0, 16'd65535, 2'd0, 16'd0);
        run_traffic(150);
        tx_calm = 1'b1;
        set_config(12'd4095, 12'd4095, 16'd1, 2'd3, 16'd1);
        run_traffic(150);
        tx_calm = 1'b0;
        rx_calm = 1'b1;
        set_config(12'd0, 12'd41, 16'd0, 2'd1, 16'd3);
        run_traffic(150);
        repeat (6) begin
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            random_config();
            run_traffic(170);
        end

        tx_calm = 1'b1;
        rx_calm = 1'b1;
        set_config(12'd205, 12'd41, 16'd999, 2'd2, 16'd60);
        push_item(make_item(CMD_DRIVE, 8192, 1000));
        repeat (62) push_item(rand_tick());

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d items under %0d register settings; %0d results checked.",
                 items_sent, settings_run, results);
        $display("Watchdog stops seen: %0d.", fires);
        if (errors == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
